/* sv/stock_span_monotonic_stack_assert.svh */
// assertion macros for the stock span block
`ifndef STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH
`define STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH

// condition a implies condition b in the same cycle
`define SSMS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("stock span check failed");

// condition a implies condition b in the next cycle
`define SSMS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("stock span check failed");

`endif

/* sv/ssms_pkg.sv */
package ssms_pkg;

   localparam int PRICE_PORT_WIDTH = 16;
   localparam int SPAN_WIDTH       = 16;

   typedef logic [SPAN_WIDTH-1:0] span_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

endpackage

/* sv/ssms_req_if.sv */
interface ssms_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [ssms_pkg::PRICE_PORT_WIDTH-1:0]  price;
   logic                                   first;

   modport source (output valid, output price, output first, input ready);
   modport sink (input valid, input price, input first, output ready);
endinterface

/* sv/ssms_rsp_if.sv */
interface ssms_rsp_if;
   logic                   valid;
   logic                   ready;
   ssms_pkg::span_type     span;
   logic                   inexact;

   modport source (output valid, output span, output inexact, input ready);
   modport sink (input valid, input span, input inexact, output ready);
endinterface

/* sv/stock_span_monotonic_stack.sv */
// Stock span engine. Each req beat carries a price and a first flag; each rsp beat returns
// the span (today plus the preceding run priced at or below today, saturating at 65535)
// and an inexact flag that marks a span reaching past an entry lost off a full stack.
// The stack is a row of STACK_DEPTH shift cells with the top entry in cell 0; only the
// top cell is compared. An item is handled in steps: the beat is taken, then entries
// are popped one per cycle through the top cell, then the item is pushed. Every entry
// is pushed once and popped at most once. The result sits in an output register, so
// the next beat is taken while it waits; a push waits only while that register is
// still occupied.
module stock_span_monotonic_stack #(
   parameter int STACK_DEPTH = 64,
   parameter int PRICE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ssms_req_if.sink    req_bus,
   ssms_rsp_if.source  rsp_bus
);

   `include "stock_span_monotonic_stack_assert.svh"

   localparam int FILL_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int SW         = ssms_pkg::SPAN_WIDTH;

   ssms_pkg::state_type      state_ff, state_in;
   logic [FILL_WIDTH-1:0]    fill_ff, fill_in;
   logic                     dropped_ff, dropped_in;
   logic [PRICE_WIDTH-1:0]   price_ff, price_in;
   ssms_pkg::span_type       days_ff, days_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ssms_pkg::span_type       span_ff, span_in;
   logic                     inexact_ff, inexact_in;

   logic [PRICE_WIDTH-1:0]   req_price;
   logic                     req_take;
   logic                     out_free;
   logic                     pop;
   logic                     push;
   logic                     full;
   logic [SW:0]              sum;
   ssms_pkg::cell_ctrl_type  ctrl;

   logic [PRICE_WIDTH-1:0]   cell_price [STACK_DEPTH];
   ssms_pkg::span_type       cell_count [STACK_DEPTH];

   generate
      if (PRICE_WIDTH <= ssms_pkg::PRICE_PORT_WIDTH) begin : g_price_narrow
         assign req_price = req_bus.price[PRICE_WIDTH-1:0];
      end else begin : g_price_wide
         assign req_price = {{(PRICE_WIDTH - ssms_pkg::PRICE_PORT_WIDTH){1'b0}},
                             req_bus.price};
      end
   endgenerate

   assign req_bus.ready = (state_ff == ssms_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign full          = (fill_ff == FILL_WIDTH'(STACK_DEPTH));
   assign pop           = (state_ff == ssms_pkg::ST_WORK) && (fill_ff != '0)
                          && (cell_price[0] <= price_ff);
   assign push          = (state_ff == ssms_pkg::ST_WORK) && !pop && out_free;
   assign sum           = {1'b0, days_ff} + {1'b0, cell_count[0]};

   assign ctrl.shift_up   = pop;
   assign ctrl.shift_down = push;

   // row of stack cells, top in cell 0
   generate
      for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic [PRICE_WIDTH-1:0] above_price, below_price;
         ssms_pkg::span_type     above_count, below_count;

         if (i == 0) begin : g_top
            assign above_price = price_ff;
            assign above_count = days_ff;
         end else begin : g_mid
            assign above_price = cell_price[i-1];
            assign above_count = cell_count[i-1];
         end

         if (i == STACK_DEPTH - 1) begin : g_bottom
            assign below_price = cell_price[i];
            assign below_count = cell_count[i];
         end else begin : g_up
            assign below_price = cell_price[i+1];
            assign below_count = cell_count[i+1];
         end

         ssms_cell #(
            .PRICE_WIDTH (PRICE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .above_price (above_price),
            .above_count (above_count),
            .below_price (below_price),
            .below_count (below_count),
            .price       (cell_price[i]),
            .count       (cell_count[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      price_in     = price_ff;
      days_in      = days_ff;
      rsp_valid_in = rsp_valid_ff;
      span_in      = span_ff;
      inexact_in   = inexact_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ssms_pkg::ST_IDLE: begin
            if (req_take) begin
               price_in = req_price;
               days_in  = SW'(1);
               state_in = ssms_pkg::ST_WORK;
               if (req_bus.first) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         ssms_pkg::ST_WORK: begin
            if (pop) begin
               days_in = sum[SW] ? '1 : sum[SW-1:0];
               fill_in = fill_ff - FILL_WIDTH'(1);
            end else if (push) begin
               // drop the bottom entry when the row is full
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + FILL_WIDTH'(1);
               end
               rsp_valid_in = 1'b1;
               span_in      = days_ff;
               inexact_in   = (fill_ff == '0) && dropped_ff;
               state_in     = ssms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssms_pkg::ST_IDLE;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff   <= price_in;
      days_ff    <= days_in;
      span_ff    <= span_in;
      inexact_ff <= inexact_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.span    = span_ff;
   assign rsp_bus.inexact = inexact_ff;

   `SSMS_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_WIDTH'(STACK_DEPTH))
   `SSMS_ASSERT_NEXT(a_take_starts_work, clock, reset, req_take, state_ff == ssms_pkg::ST_WORK)
   `SSMS_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop, fill_ff == $past(fill_ff) - FILL_WIDTH'(1))
   `SSMS_ASSERT_NEXT(a_full_push_drops, clock, reset, push && full, dropped_ff && rsp_valid_ff)

endmodule

/* sv/ssms_cell.sv */
module ssms_cell #(
   parameter int PRICE_WIDTH = 16
) (
   input  logic                          clock,
   input  ssms_pkg::cell_ctrl_type       ctrl,
   input  logic [PRICE_WIDTH-1:0]        above_price,
   input  ssms_pkg::span_type            above_count,
   input  logic [PRICE_WIDTH-1:0]        below_price,
   input  ssms_pkg::span_type            below_count,
   output logic [PRICE_WIDTH-1:0]        price,
   output ssms_pkg::span_type            count
);

   logic [PRICE_WIDTH-1:0] price_ff, price_in;
   ssms_pkg::span_type     count_ff, count_in;

   always_comb begin
      price_in = price_ff;
      count_in = count_ff;
      if (ctrl.shift_down) begin
         price_in = above_price;
         count_in = above_count;
      end else if (ctrl.shift_up) begin
         price_in = below_price;
         count_in = below_count;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      count_ff <= count_in;
   end

   assign price = price_ff;
   assign count = count_ff;

endmodule

/* tb/span_checker.sv */
module span_checker #(
   parameter int DEPTH = 64
) (
   input  logic  clock,
   input  logic  reset,
   ssms_req_if   req_mon,
   ssms_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SPAN_LIMIT = 2**ssms_pkg::SPAN_WIDTH - 1;

   typedef struct packed {
      ssms_pkg::span_type span;
      logic               inexact;
   } span_beat_type;

   logic [ssms_pkg::PRICE_PORT_WIDTH-1:0] level_price [DEPTH];
   ssms_pkg::span_type                    level_count [DEPTH];
   int                                    fill;
   bit                                    lost_bottom;
   span_beat_type                         span_queue [$];
   int                                    errors;
   int                                    beat_no;

   function automatic span_beat_type next_span(
         input logic [ssms_pkg::PRICE_PORT_WIDTH-1:0] price,
         input logic first);
      int            days;
      span_beat_type r;
      if (first) begin
         fill = 0;
         lost_bottom = 0;
      end
      days = 1;
      while (fill > 0 && level_price[fill-1] <= price) begin
         days += level_count[fill-1];
         if (days > SPAN_LIMIT)
            days = SPAN_LIMIT;
         fill--;
      end
      r.inexact = (fill == 0) && lost_bottom;
      // drop the bottom entry of a full stack
      if (fill == DEPTH) begin
         for (int i = 0; i < DEPTH-1; i++) begin
            level_price[i] = level_price[i+1];
            level_count[i] = level_count[i+1];
         end
         fill--;
         lost_bottom = 1;
      end
      level_price[fill] = price;
      level_count[fill] = ssms_pkg::span_type'(days);
      fill++;
      r.span = ssms_pkg::span_type'(days);
      return r;
   endfunction

   always @(posedge clock) begin
      span_beat_type want;
      if (reset) begin
         fill = 0;
         lost_bottom = 0;
         errors = 0;
         beat_no = 0;
         span_queue.delete();
         pending <= 0;
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (span_queue.size() == 0) begin
               if (errors < 10)
                  $display("span check: unexpected rsp beat %0d, span %0d inexact %0b",
                           beat_no, rsp_mon.span, rsp_mon.inexact);
               errors++;
            end else begin
               want = span_queue.pop_front();
               if (want.span !== rsp_mon.span || want.inexact !== rsp_mon.inexact) begin
                  if (errors < 10)
                     $display("span check: beat %0d want span %0d inexact %0b, got %0d %0b",
                              beat_no, want.span, want.inexact,
                              rsp_mon.span, rsp_mon.inexact);
                  errors++;
               end
            end
            beat_no++;
         end
         if (req_mon.valid && req_mon.ready)
            span_queue.insert(span_queue.size(), next_span(req_mon.price, req_mon.first));
         pending <= span_queue.size();
         fail_count <= errors;
      end
   end

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH  = 64;
   localparam int PRICE_WIDTH  = 16;
   localparam int RANDOM_ITEMS = 900;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 200;

   logic clock;
   logic reset;
   int   span_errors;
   int   spans_waiting;
   int   hold_asks;
   int   burst_left;
   bit   steady;

   ssms_req_if req_bus ();
   ssms_rsp_if rsp_bus ();

   stock_span_monotonic_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .PRICE_WIDTH (PRICE_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   span_checker #(
      .DEPTH (STACK_DEPTH)
   ) span_check_u (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (span_errors),
      .pending    (spans_waiting)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #20_000_000;
      $display("stock_span_monotonic_stack: mismatch");
      $finish;
   end

   initial begin
      int mode;
      int left;
      int hold;
      int hold_taken;
      rsp_bus.ready = 1'b0;
      mode = 0;
      left = 0;
      hold = 0;
      hold_taken = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_taken != hold_asks) begin
            hold_taken++;
            hold = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 128);
            end
            left--;
            case (mode)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_bus.ready <= (left % 5 != 0);
               end
            endcase
         end
      end
   end

   task automatic offer(input logic [ssms_pkg::PRICE_PORT_WIDTH-1:0] price,
                        input logic first);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 && !steady) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.price <= price;
      req_bus.first <= first;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (spans_waiting != 0);
   endtask

   initial begin
      int                                    style;
      int                                    len;
      int                                    series_no;
      int                                    random_sent;
      logic                                  first;
      logic [ssms_pkg::PRICE_PORT_WIDTH-1:0] walk;
      logic [ssms_pkg::PRICE_PORT_WIDTH-1:0] price;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.price = '0;
      req_bus.first = 1'b0;
      hold_asks = 0;
      burst_left = 0;
      steady = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      offer(16'h0000, 1'b1);
      offer(16'h0000, 1'b0);
      offer(16'hFFFF, 1'b0);
      offer(16'hFFFF, 1'b0);
      offer(16'd100, 1'b0);
      offer(16'd200, 1'b0);
      offer(16'd150, 1'b0);
      offer(16'hFFFE, 1'b0);
      offer(16'hFFFF, 1'b1);
      offer(16'h0000, 1'b1);
      offer(16'h5555, 1'b0);
      offer(16'hAAAA, 1'b0);
      drain();

      series_no = 0;
      random_sent = 0;
      walk = '0;
      while (random_sent < RANDOM_ITEMS) begin
         if (series_no == 0) begin
            style = 2;
            len = 90;
         end else begin
            style = $urandom_range(0, 3);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 130)
                                              : $urandom_range(1, 30);
         end
         if (series_no == 3) begin
            hold_asks <= hold_asks + 1;
            steady = 1;
            len = 60;
         end
         if (series_no == 8)
            drain();
         walk = (style == 2) ? 16'($urandom_range(50000, 65535))
                             : 16'($urandom_range(0, 20000));
         for (int k = 0; k < len; k++) begin
            case (style)
               0: begin
                  price = 16'($urandom_range(0, 65535));
               end
               1: begin
                  price = 16'($urandom_range(0, 7));
               end
               2: begin
                  if (series_no != 0 && $urandom_range(0, 15) == 0)
                     walk = 16'($urandom_range(0, 65535));
                  else if (walk < 16'd400)
                     walk = 16'($urandom_range(30000, 65535));
                  else
                     walk = walk - 16'($urandom_range(1, 399));
                  price = walk;
               end
               default: begin
                  walk = (int'(walk) + 300 > 65535) ? 16'hFFFF
                                                    : walk + 16'($urandom_range(0, 300));
                  price = walk;
               end
            endcase
            if (series_no == 0 && k == len - 1)
               price = 16'hFFFF;
            if (k == 0)
               first = ($urandom_range(0, 7) != 0);
            else
               first = (style == 0 && $urandom_range(0, 63) == 0);
            offer(price, first);
            random_sent++;
         end
         steady = 0;
         series_no++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (span_errors == 0 && spans_waiting == 0)
         $display("stock_span_monotonic_stack: match");
      else
         $display("stock_span_monotonic_stack: mismatch");
      $finish;
   end

endmodule
